### sv/gcpf_pkg.sv
// Contact-pair force unit: shared constants, register codes and the
// saturation helper. No dependencies.
package gcpf_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int CUTOFF_FACTOR_DEF = 3;

	localparam int FIELD_W   = 32;  // width of every coordinate / depth field
	localparam int LIMB      = 32;  // multiplier partial product operand width
	localparam int MUL_LAT   = 2;   // cycles through one wide multiplier
	localparam int UFRAC     = 40;  // fraction bits of u and its powers
	localparam int UCAP      = 43;  // u limited to 2^UCAP (8.0)
	localparam int KDROP     = 34;
	localparam int KEXTRA    = 6;
	localparam int FQ        = 32;  // quotient bits of the force division

	localparam int ADW   = FIELD_W + 1;          // |difference|
	localparam int RW    = 2 * ADW;              // squared length
	localparam int UW    = UCAP + 1;             // u including its limit
	localparam int PW    = UFRAC + 3 * 6 + 1;    // u^k, k <= 6, u <= 8
	localparam int TSW   = PW + 3;               // 5u^6 - 6u^5, signed
	localparam int WSW   = PW + 1;               // u^6 - u^5, signed
	localparam int DEPW  = FIELD_W + 2;          // effective depth, signed
	localparam int ADEPW = FIELD_W + 1;          // |depth|
	localparam int MDW   = ADEPW + 6;            // multiplier times |depth|
	localparam int KW    = 64;

	localparam logic [2:0] POLY_U6 = 3'd5;
	localparam logic [2:0] POLY_U5 = 3'd6;
	localparam logic [5:0] MULT_NATIVE = 6'd60;
	localparam logic [5:0] MULT_REP    = 6'd12;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_NATIVE_DEPTH    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_REPULSIVE_DEPTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NOISE_ENABLE    = 2'd2;

	localparam logic [FIELD_W-1:0] DEPTH_RESET = 32'd65536;

	// clip magnitude to the signed 32-bit range, apply sign; msb is the clip flag
	function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
		logic [63:0] limit;
		logic        clip;
		logic [31:0] m;
		limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
		clip  = mag > limit;
		m     = clip ? limit[31:0] : mag[31:0];
		return {clip, neg ? (32'd0 - m) : m};
	endfunction

endpackage

### sv/gcpf_dly.sv
// Contact-pair force unit: enable-gated delay line for side data.
// No dependencies.
module gcpf_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) tap_s[i] <= '0;
		end else if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < N; i++) tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[N-1];
endmodule

### sv/gcpf_mul.sv
// Contact-pair force unit: two-stage unsigned multiplier built from
// LIMB x LIMB partial products. Depends on gcpf_pkg.
module gcpf_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic               clk,
	input  logic               en,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic [AW+BW-1:0]   prod
);
	import gcpf_pkg::*;

	localparam int NA = (AW + LIMB - 1) / LIMB;
	localparam int NB = (BW + LIMB - 1) / LIMB;
	localparam int XW = (NA + NB) * LIMB;

	logic [NA*LIMB-1:0] a_x;
	logic [NB*LIMB-1:0] b_x;
	logic [2*LIMB-1:0]  pp_s1 [NA*NB];
	logic [XW-1:0]      sum_c;

	assign a_x = (NA*LIMB)'(a);
	assign b_x = (NB*LIMB)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i*NB+j] <= a_x[i*LIMB +: LIMB] * b_x[j*LIMB +: LIMB];
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++)
			for (int j = 0; j < NB; j++)
				sum_c = sum_c + (XW'(pp_s1[i*NB+j]) << (LIMB * (i + j)));
	end

	always_ff @(posedge clk) begin
		if (en) prod <= (AW+BW)'(sum_c);
	end
endmodule

### sv/gcpf_div.sv
// Contact-pair force unit: pipelined restoring divider, one quotient bit per
// stage, result limited to 2^QW (also for a zero divisor). Depends on gcpf_pkg.
module gcpf_div #(
	parameter int NW = 104,
	parameter int DW = 66,
	parameter int QW = 43
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW:0]   quo
);
	import gcpf_pkg::*;

	localparam int MW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW+1];
	logic          cap_s [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			cap_s[0] <= (den == '0) || (MW'(num) >= (MW'(den) << QW));
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_bit
		localparam int B = QW - k;
		logic [MW-1:0] sub_c;
		logic          ge_c;

		assign sub_c = MW'(den_s[k-1]) << B;
		assign ge_c  = MW'(rem_s[k-1]) >= sub_c;

		// bit B is still clear in the incoming partial quotient
		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_s[k-1] | (QW'(ge_c) << B);
				cap_s[k] <= cap_s[k-1];
			end
		end

		if (k < QW) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge_c ? NW'(MW'(rem_s[k-1]) - sub_c) : rem_s[k-1];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = cap_s[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, quo_s[QW]};
endmodule

### sv/go_contact_pair_force.sv
// Contact-pair force unit, top level: 10-12 native well / 12 repulsion.
// Depends on gcpf_pkg, gcpf_dly, gcpf_mul and gcpf_div.
//
// Usage
//  s_* : one pair per transaction (positions, contact radius, depth offset in
//        s_tdata, native flag in s_tuser).
//  m_* : energy and force on the second particle in m_tdata, cutoff and
//        saturation flags in m_tuser. The first particle takes the negated force.
//  cfg_*: register writes, taken on any edge with cfg_we high; only while idle.
// Throughput: one transaction per cycle while no result is held back by m_tready.
// The two divider chains (u = sigma^2/R and the force scaling) dominate the
//  delay from acceptance to m_tvalid; every multiplier adds its partial-product
//  and sum registers.
// The whole pipeline moves on one enable: when m_tvalid is held by a low
//  m_tready, s_tready drops and every stage holds, so nothing is lost or
//  repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits and loads depths of 1.0 and noise off; no
//  memory clearing is needed.
module go_contact_pair_force #(
	parameter int FRAC_BITS     = gcpf_pkg::FRAC_BITS_DEF,
	parameter int CUTOFF_FACTOR = gcpf_pkg::CUTOFF_FACTOR_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z,
	// contact_radius, depth_deviation
	input  logic [255:0]                    s_tdata,
	// is_native
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pair_energy, force_x, force_y, force_z
	output logic [127:0]                    m_tdata,
	// within_cutoff, saturated
	output logic [1:0]                      m_tuser,
	input  logic                            cfg_we,
	input  logic [gcpf_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [gcpf_pkg::FIELD_W-1:0]    cfg_data
);
	import gcpf_pkg::*;

	localparam int LW  = FIELD_W + $clog2(CUTOFF_FACTOR + 1);
	localparam int CMW = (2 * LW > RW + 2) ? 2 * LW : RW + 2;
	localparam int BFW = ADW + FRAC_BITS;

	// cycle at which each value sits in its register
	localparam int T1 = 1;
	localparam int T2 = T1 + MUL_LAT;
	localparam int TR = T2 + 1;
	localparam int TU = TR + UCAP + 1;
	localparam int T6 = TU + 5 * MUL_LAT;
	localparam int TW = T6 + 1;
	localparam int TK = TW + MUL_LAT;
	localparam int TE = TK + 1;
	localparam int TP = TK + MUL_LAT;
	localparam int TF = TP + FQ + 1;

	logic [FIELD_W-1:0] native_q, repulsive_q;
	logic               noise_q;
	logic               en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_q    <= DEPTH_RESET;
			repulsive_q <= DEPTH_RESET;
			noise_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NATIVE_DEPTH:    native_q    <= cfg_data;
				REG_REPULSIVE_DEPTH: repulsive_q <= cfg_data;
				REG_NOISE_ENABLE:    noise_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: differences, cutoff radius, effective depth
	logic signed [ADW-1:0]  d_c [3];
	logic [ADW-1:0]         ad_c [3];
	logic [LW-1:0]          lim_c;
	logic signed [DEPW-1:0] dep_c;
	logic [FIELD_W-1:0]     dev;

	assign dev = s_tdata[255:224];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d_c[c] = $signed({s_tdata[(c+3)*32+31], s_tdata[(c+3)*32 +: 32]})
			       - $signed({s_tdata[c*32+31], s_tdata[c*32 +: 32]});
			ad_c[c] = d_c[c][ADW-1] ? ADW'(-d_c[c]) : ADW'(d_c[c]);
		end
		lim_c = LW'(s_tdata[223:192]) * LW'(CUTOFF_FACTOR);
		if (s_tuser)
			dep_c = $signed({2'b00, native_q})
			      + (noise_q ? $signed({{2{dev[31]}}, dev}) : DEPW'(0));
		else
			dep_c = $signed({2'b00, repulsive_q});
	end

	logic [ADW-1:0]         ad_s1 [3];
	logic [2:0]             dsg_s1, dzr_s1;
	logic [FIELD_W-1:0]     sigma_s1;
	logic [LW-1:0]          lim_s1;
	logic                   nat_s1;
	logic signed [DEPW-1:0] dep_s1;
	logic                   v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				ad_s1[c]  <= ad_c[c];
				dsg_s1[c] <= d_c[c][ADW-1];
				dzr_s1[c] <= (d_c[c] == '0);
			end
			sigma_s1 <= s_tdata[223:192];
			lim_s1   <= lim_c;
			nat_s1   <= s_tuser;
			dep_s1   <= dep_c;
		end
	end

	// ---- squares
	logic [RW-1:0]        sq [3];
	logic [2*FIELD_W-1:0] sig2;
	logic [2*LW-1:0]      lim2;

	for (genvar c = 0; c < 3; c++) begin : g_sq
		gcpf_mul #(.AW(ADW), .BW(ADW)) u_sq (
			.clk(clk), .en(en), .a(ad_s1[c]), .b(ad_s1[c]), .prod(sq[c]));
	end

	gcpf_mul #(.AW(FIELD_W), .BW(FIELD_W)) u_sig2 (
		.clk(clk), .en(en), .a(sigma_s1), .b(sigma_s1), .prod(sig2));

	gcpf_mul #(.AW(LW), .BW(LW)) u_lim2 (
		.clk(clk), .en(en), .a(lim_s1), .b(lim_s1), .prod(lim2));

	// ---- stage 2: squared length and cutoff test
	logic [CMW-1:0]       rsum_c;
	logic [RW-1:0]        r_s2;
	logic                 within_s2;
	logic [2*FIELD_W-1:0] sig2_s2;

	assign rsum_c = CMW'(sq[0]) + CMW'(sq[1]) + CMW'(sq[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2      <= RW'(rsum_c);
			within_s2 <= CMW'(lim2) >= rsum_c;
			sig2_s2   <= sig2;
		end
	end

	// ---- u = sigma^2 / R in Q.40, limited to 8
	logic [UW-1:0] u_tu;

	gcpf_div #(.NW(2*FIELD_W+UFRAC), .DW(RW), .QW(UCAP)) u_udiv (
		.clk(clk), .en(en), .num({sig2_s2, {UFRAC{1'b0}}}), .den(r_s2), .quo(u_tu));

	// ---- powers u^2 .. u^6
	logic [PW-1:0]    pw [2:6];
	logic [UW-1:0]    ud [2:5];
	logic [2*UW-1:0]  p2prod;
	logic [PW-1:0]    u5_t6;

	gcpf_mul #(.AW(UW), .BW(UW)) u_p2 (
		.clk(clk), .en(en), .a(u_tu), .b(u_tu), .prod(p2prod));
	assign pw[2] = PW'(p2prod >> UFRAC);

	gcpf_dly #(.W(UW), .N(MUL_LAT)) u_ud2 (
		.clk(clk), .arst_n(arst_n), .en(en), .din(u_tu), .dout(ud[2]));

	for (genvar k = 3; k <= 5; k++) begin : g_ud
		gcpf_dly #(.W(UW), .N(MUL_LAT)) u_ud (
			.clk(clk), .arst_n(arst_n), .en(en), .din(ud[k-1]), .dout(ud[k]));
	end

	for (genvar k = 2; k <= 5; k++) begin : g_pow
		logic [PW+UW-1:0] pprod;
		gcpf_mul #(.AW(PW), .BW(UW)) u_pk (
			.clk(clk), .en(en), .a(pw[k]), .b(ud[k]), .prod(pprod));
		assign pw[k+1] = PW'(pprod >> UFRAC);
	end

	gcpf_dly #(.W(PW), .N(MUL_LAT)) u_u5 (
		.clk(clk), .arst_n(arst_n), .en(en), .din(pw[5]), .dout(u5_t6));

	// ---- stage 3: energy and force polynomials
	logic                   nat_t6;
	logic signed [DEPW-1:0] dep_t6;

	gcpf_dly #(.W(DEPW+1), .N(T6-T1)) u_dep (
		.clk(clk), .arst_n(arst_n), .en(en), .din({nat_s1, dep_s1}),
		.dout({nat_t6, dep_t6}));

	logic [TSW-1:0]   t_c;
	logic [WSW-1:0]   w_c;
	logic [ADEPW-1:0] adep_c;

	always_comb begin
		if (nat_t6) begin
			t_c = TSW'(pw[6]) * TSW'(POLY_U6) - TSW'(u5_t6) * TSW'(POLY_U5);
			w_c = WSW'(pw[6]) - WSW'(u5_t6);
		end else begin
			t_c = TSW'(pw[6]);
			w_c = WSW'(pw[6]);
		end
		adep_c = dep_t6[DEPW-1] ? ADEPW'(-dep_t6) : ADEPW'(dep_t6);
	end

	logic [TSW-1:0]   tmag_s3;
	logic [PW-1:0]    wmag_s3;
	logic [ADEPW-1:0] adep_s3;
	logic [MDW-1:0]   madep_s3;
	logic             eneg_s3, fneg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tmag_s3  <= t_c[TSW-1] ? (TSW'(0) - t_c) : t_c;
			wmag_s3  <= PW'(w_c[WSW-1] ? (WSW'(0) - w_c) : w_c);
			adep_s3  <= adep_c;
			madep_s3 <= MDW'(adep_c) * MDW'(nat_t6 ? MULT_NATIVE : MULT_REP);
			eneg_s3  <= dep_t6[DEPW-1] ^ t_c[TSW-1];
			fneg_s3  <= dep_t6[DEPW-1] ^ w_c[WSW-1];
		end
	end

	// ---- energy magnitude and force scale K
	logic [ADEPW+TSW-1:0] eprod;
	logic [MDW+PW-1:0]    kprod;
	logic [KW-1:0]        kq;
	logic                 eneg_tk;

	gcpf_mul #(.AW(ADEPW), .BW(TSW)) u_emul (
		.clk(clk), .en(en), .a(adep_s3), .b(tmag_s3), .prod(eprod));

	gcpf_mul #(.AW(MDW), .BW(PW)) u_kmul (
		.clk(clk), .en(en), .a(madep_s3), .b(wmag_s3), .prod(kprod));

	assign kq = KW'(kprod >> KDROP);

	gcpf_dly #(.W(1), .N(TK-TW)) u_eneg (
		.clk(clk), .arst_n(arst_n), .en(en), .din(eneg_s3), .dout(eneg_tk));

	// ---- stage 4: energy saturation
	logic [32:0] esat_s4, esat_tf;

	always_ff @(posedge clk) begin
		if (en) esat_s4 <= sat32(eneg_tk, 64'(eprod >> UFRAC));
	end

	gcpf_dly #(.W(33), .N(TF-TE)) u_esat (
		.clk(clk), .arst_n(arst_n), .en(en), .din(esat_s4), .dout(esat_tf));

	// ---- force components: K * |D| * 2^F / (R * 2^6)
	logic [3*ADW-1:0] ad_tk;
	logic [RW-1:0]    r_tp;

	gcpf_dly #(.W(3*ADW), .N(TK-T1)) u_ad (
		.clk(clk), .arst_n(arst_n), .en(en), .din({ad_s1[2], ad_s1[1], ad_s1[0]}),
		.dout(ad_tk));

	gcpf_dly #(.W(RW), .N(TP-TR)) u_r (
		.clk(clk), .arst_n(arst_n), .en(en), .din(r_s2), .dout(r_tp));

	logic [FQ:0] fq [3];

	for (genvar c = 0; c < 3; c++) begin : g_force
		logic [KW+BFW-1:0] fprod;
		gcpf_mul #(.AW(KW), .BW(BFW)) u_fmul (
			.clk(clk), .en(en), .a(kq),
			.b(BFW'(ad_tk[c*ADW +: ADW]) << FRAC_BITS), .prod(fprod));
		gcpf_div #(.NW(KW+BFW), .DW(RW+KEXTRA), .QW(FQ)) u_fdiv (
			.clk(clk), .en(en), .num(fprod), .den({r_tp, {KEXTRA{1'b0}}}),
			.quo(fq[c]));
	end

	// ---- side data to the output stage
	logic [2:0] dsg_tf, dzr_tf;
	logic       within_tf, fneg_tf, v_tf;

	gcpf_dly #(.W(6), .N(TF-T1)) u_dflag (
		.clk(clk), .arst_n(arst_n), .en(en), .din({dsg_s1, dzr_s1}),
		.dout({dsg_tf, dzr_tf}));

	gcpf_dly #(.W(1), .N(TF-TR)) u_within (
		.clk(clk), .arst_n(arst_n), .en(en), .din(within_s2), .dout(within_tf));

	gcpf_dly #(.W(1), .N(TF-TW)) u_fneg (
		.clk(clk), .arst_n(arst_n), .en(en), .din(fneg_s3), .dout(fneg_tf));

	gcpf_dly #(.W(1), .N(TF-T1)) u_valid (
		.clk(clk), .arst_n(arst_n), .en(en), .din(v_s1), .dout(v_tf));

	// ---- stage 5: force saturation and output register
	logic [32:0] fsat_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			fsat_c[c] = dzr_tf[c] ? 33'd0 : sat32(fneg_tf ^ dsg_tf[c], 64'(fq[c]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_tf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (within_tf) begin
				m_tdata <= {fsat_c[2][31:0], fsat_c[1][31:0], fsat_c[0][31:0],
				            esat_tf[31:0]};
				m_tuser <= {esat_tf[32] | fsat_c[0][32] | fsat_c[1][32] | fsat_c[2][32],
				            1'b1};
			end else begin
				m_tdata <= '0;
				m_tuser <= 2'b00;
			end
		end
	end
endmodule

### sv/gcpf_chk.sv
// Contact-pair force unit: port-level checker and its bind to the top level.
// Depends on go_contact_pair_force.
module gcpf_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser
);
	// the input side only stalls when a result is held back
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output backpressure");

	// beyond cutoff everything is zero and nothing is flagged as clipped
	a_cutoff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
		else $error("result outside cutoff is not zero");

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output transaction changed");
endmodule

bind go_contact_pair_force gcpf_chk u_chk (.*);
